// ===== rtl/hres_pkg.sv =====
// ----------------------------------------------------------------------------
// hres_pkg: shared types, constants and saturating helpers
// Q15.32 value formats, the point record passed between cells and the
// saturating add/sub/scale functions used by every substep cell.
// ----------------------------------------------------------------------------
`default_nettype none

package hres_pkg;

	localparam int VAL_W         = 48;
	localparam int EXT_W         = VAL_W + 4;
	localparam int DT_W          = 33;
	localparam int CFG_IDX_W     = 2;
	localparam int SUBSTEPS_DEF  = 11;
	localparam int FRAC_BITS_DEF = 32;

	localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [DT_W-1:0]  DT_RESET  = 33'd4294967;
	localparam logic [VAL_W-1:0] CUR_RESET = 48'd13486197309;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP     = 2'd0,
		CFG_INPUT_CURRENT = 2'd1
	} hres_cfg_t;

	typedef struct packed {
		logic             ovf;
		logic [VAL_W-1:0] val;
	} hres_sat_t;

	typedef struct packed {
		logic             flag;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
	} hres_pt_t;

	function automatic logic [EXT_W-1:0] ext(input logic [VAL_W-1:0] a);
		return {{(EXT_W-VAL_W){a[VAL_W-1]}}, a};
	endfunction

	// Clamp an extended two's-complement value to the 48-bit range.
	function automatic hres_sat_t sat(input logic [EXT_W-1:0] v);
		hres_sat_t r;
		logic      all1;
		logic      all0;
		all1  = &v[EXT_W-1:VAL_W-1];
		all0  = ~|v[EXT_W-1:VAL_W-1];
		r.ovf = !(all1 || all0);
		if (r.ovf)
			r.val = v[EXT_W-1] ? VAL_MIN : VAL_MAX;
		else
			r.val = v[VAL_W-1:0];
		return r;
	endfunction

	function automatic hres_sat_t sat_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		return sat(ext(a) + ext(b));
	endfunction

	function automatic hres_sat_t sat_sub(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		return sat(ext(a) - ext(b));
	endfunction

	function automatic hres_sat_t sat_neg(input logic [VAL_W-1:0] a);
		return sat({EXT_W{1'b0}} - ext(a));
	endfunction

	function automatic hres_sat_t sat_mul3(input logic [VAL_W-1:0] a);
		return sat(ext(a) + (ext(a) << 1));
	endfunction

	function automatic hres_sat_t sat_mul4(input logic [VAL_W-1:0] a);
		return sat(ext(a) << 2);
	endfunction

	function automatic hres_sat_t sat_mul5(input logic [VAL_W-1:0] a);
		return sat(ext(a) + (ext(a) << 2));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hres_mul.sv =====
// ----------------------------------------------------------------------------
// hres_mul: pipelined saturating fixed-point multiplier
// Signed 48x48 product from four half-width partial products, floored
// by FRAC_BITS and clamped to 48 bits. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hres_mul
	import hres_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	output logic [VAL_W-1:0] p,
	output logic             ovf
);

	localparam int Half = VAL_W / 2;
	localparam int PW   = 2 * VAL_W;

	logic signed [Half-1:0] ah;
	logic signed [Half-1:0] bh;
	logic        [Half-1:0] al;
	logic        [Half-1:0] bl;

	logic signed [VAL_W-1:0] hh_s1;
	logic signed [VAL_W:0]   hl_s1;
	logic signed [VAL_W:0]   lh_s1;
	logic        [VAL_W-1:0] ll_s1;
	logic        [PW-1:0]    prod_s2;
	logic        [VAL_W-1:0] p_s3;
	logic                    ovf_s3;

	logic hi_all1;
	logic hi_all0;

	assign ah = a[VAL_W-1:Half];
	assign al = a[Half-1:0];
	assign bh = b[VAL_W-1:Half];
	assign bl = b[Half-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * $signed({1'b0, bl});
			lh_s1 <= $signed({1'b0, al}) * bh;
			ll_s1 <= al * bl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {hh_s1, {VAL_W{1'b0}}}
				+ {{(Half-1){hl_s1[VAL_W]}}, hl_s1, {Half{1'b0}}}
				+ {{(Half-1){lh_s1[VAL_W]}}, lh_s1, {Half{1'b0}}}
				+ {{VAL_W{1'b0}}, ll_s1};
		end
	end

	// Dropping the low bits of the two's-complement product floors it.
	assign hi_all1 = &prod_s2[PW-1:FRAC_BITS+VAL_W-1];
	assign hi_all0 = ~|prod_s2[PW-1:FRAC_BITS+VAL_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s3 <= !(hi_all1 || hi_all0);
			if (hi_all1 || hi_all0)
				p_s3 <= prod_s2[FRAC_BITS+VAL_W-1:FRAC_BITS];
			else
				p_s3 <= prod_s2[PW-1] ? VAL_MIN : VAL_MAX;
		end
	end

	assign p   = p_s3;
	assign ovf = ovf_s3;

endmodule

`default_nettype wire

// ===== rtl/hres_cell.sv =====
// ----------------------------------------------------------------------------
// hres_cell: one forward Euler substep
// Takes a point from its left neighbor and hands the advanced point to
// its right neighbor through its pipeline registers, which move with en.
// ----------------------------------------------------------------------------
`default_nettype none

module hres_cell
	import hres_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [VAL_W-1:0] step,
	input  logic [VAL_W-1:0] cur,
	input  logic             prev_vld,
	input  hres_pt_t         prev_pt,
	output logic             next_vld,
	output hres_pt_t         next_pt
);

	localparam int Lat = 15;
	localparam longint OneL = longint'(1) << FRAC_BITS;
	localparam logic [VAL_W-1:0] OneFx  = VAL_W'(OneL);
	localparam logic [VAL_W-1:0] RateFx = VAL_W'((OneL * 2 + 500) / 1000);
	localparam logic [VAL_W-1:0] XrFx   = VAL_W'(-((OneL * 16 + 5) / 10));

	hres_pt_t         pt_q [1:Lat];
	logic [Lat:1]     vld_q;
	logic [Lat:1]     stage_ovf;

	logic [VAL_W-1:0] tz_s [1:3];
	logic [VAL_W-1:0] c3_s [4:7];
	logic [VAL_W-1:0] c5_s4;
	logic [VAL_W-1:0] dy_s [5:11];
	logic [VAL_W-1:0] dz_s [7:11];
	logic [VAL_W-1:0] t_s7;
	logic [VAL_W-1:0] t_s8;
	logic [VAL_W-1:0] dx_s [9:11];

	logic [VAL_W-1:0] x2, x3, dz, hdx, hdy, hdz;
	logic             x2_ovf, x3_ovf, dz_ovf, hdx_ovf, hdy_ovf, hdz_ovf;

	hres_sat_t r_tz1, r_tz2, r_tz3, r_c3, r_c5, r_dy5, r_dy6;
	hres_sat_t r_t7, r_t8, r_dx9, r_dx10, r_dx11, r_nx, r_ny, r_nz;

	// Product units: x^2, x^3, rate term and the three step products.
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_sq (
		.clk(clk), .en(en), .a(prev_pt.x), .b(prev_pt.x), .p(x2), .ovf(x2_ovf)
	);
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_cube (
		.clk(clk), .en(en), .a(x2), .b(pt_q[3].x), .p(x3), .ovf(x3_ovf)
	);
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_rate (
		.clk(clk), .en(en), .a(RateFx), .b(tz_s[3]), .p(dz), .ovf(dz_ovf)
	);
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_hx (
		.clk(clk), .en(en), .a(step), .b(dx_s[11]), .p(hdx), .ovf(hdx_ovf)
	);
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_hy (
		.clk(clk), .en(en), .a(step), .b(dy_s[11]), .p(hdy), .ovf(hdy_ovf)
	);
	hres_mul #(.FRAC_BITS(FRAC_BITS)) u_hz (
		.clk(clk), .en(en), .a(step), .b(dz_s[11]), .p(hdz), .ovf(hdz_ovf)
	);

	always_comb begin
		r_tz1  = sat_sub(prev_pt.x, XrFx);
		r_tz2  = sat_mul4(tz_s[1]);
		r_tz3  = sat_sub(tz_s[2], pt_q[2].z);
		r_c3   = sat_mul3(x2);
		r_c5   = sat_mul5(x2);
		r_dy5  = sat_sub(OneFx, c5_s4);
		r_dy6  = sat_sub(dy_s[5], pt_q[5].y);
		r_t7   = sat_neg(x3);
		r_t8   = sat_add(t_s7, c3_s[7]);
		r_dx9  = sat_add(pt_q[8].y, t_s8);
		r_dx10 = sat_sub(dx_s[9], pt_q[9].z);
		r_dx11 = sat_add(dx_s[10], cur);
		r_nx   = sat_add(pt_q[14].x, hdx);
		r_ny   = sat_add(pt_q[14].y, hdy);
		r_nz   = sat_add(pt_q[14].z, hdz);
	end

	// Clamp events, folded into the point flag at the stage they appear.
	always_comb begin
		stage_ovf     = '0;
		stage_ovf[1]  = r_tz1.ovf;
		stage_ovf[2]  = r_tz2.ovf;
		stage_ovf[3]  = r_tz3.ovf;
		stage_ovf[4]  = x2_ovf | r_c3.ovf | r_c5.ovf;
		stage_ovf[5]  = r_dy5.ovf;
		stage_ovf[6]  = r_dy6.ovf;
		stage_ovf[7]  = x3_ovf | dz_ovf | r_t7.ovf;
		stage_ovf[8]  = r_t8.ovf;
		stage_ovf[9]  = r_dx9.ovf;
		stage_ovf[10] = r_dx10.ovf;
		stage_ovf[11] = r_dx11.ovf;
		stage_ovf[15] = hdx_ovf | hdy_ovf | hdz_ovf | r_nx.ovf | r_ny.ovf | r_nz.ovf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_q[1] <= '{flag: prev_pt.flag | stage_ovf[1],
				x: prev_pt.x, y: prev_pt.y, z: prev_pt.z};
			for (int k = 2; k < Lat; k++)
				pt_q[k] <= '{flag: pt_q[k-1].flag | stage_ovf[k],
					x: pt_q[k-1].x, y: pt_q[k-1].y, z: pt_q[k-1].z};
			pt_q[Lat] <= '{flag: pt_q[Lat-1].flag | stage_ovf[Lat],
				x: r_nx.val, y: r_ny.val, z: r_nz.val};

			tz_s[1] <= r_tz1.val;
			tz_s[2] <= r_tz2.val;
			tz_s[3] <= r_tz3.val;

			c3_s[4] <= r_c3.val;
			c5_s4   <= r_c5.val;
			for (int k = 5; k <= 7; k++)
				c3_s[k] <= c3_s[k-1];

			dy_s[5] <= r_dy5.val;
			dy_s[6] <= r_dy6.val;
			for (int k = 7; k <= 11; k++)
				dy_s[k] <= dy_s[k-1];

			dz_s[7] <= dz;
			for (int k = 8; k <= 11; k++)
				dz_s[k] <= dz_s[k-1];

			t_s7     <= r_t7.val;
			t_s8     <= r_t8.val;
			dx_s[9]  <= r_dx9.val;
			dx_s[10] <= r_dx10.val;
			dx_s[11] <= r_dx11.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-1:1], prev_vld};
		end
	end

	assign next_vld = vld_q[Lat];
	assign next_pt  = pt_q[Lat];

endmodule

`default_nettype wire

// ===== rtl/hindmarsh_rose_euler_step_unit.sv =====
// ----------------------------------------------------------------------------
// hindmarsh_rose_euler_step_unit: Hindmarsh-Rose point advance by one dt
// Streams (x, y, z) points through a row of forward Euler substep cells.
// ----------------------------------------------------------------------------
// Usage:
//   Point channel (point_valid/point_stall) carries fast_in, recovery_in and
//   adaptation_in; an item is taken when point_valid is high and point_stall
//   low. Result channel (result_valid/result_stall) returns the advanced
//   point and the saturated flag, one item per input, in order.
//   Throughput: one item per cycle while point_stall is low. Each item
//   passes through the row of substep cells, each holding three 3-stage
//   multiplier passes and the saturating add chain, and then through the
//   output register.
//   Configuration: cfg_index 0 writes time_step (low 33 bits of cfg_data),
//   index 1 writes input_current; other indexes are dropped. A time_step
//   write starts a reciprocal multiply for dt / SUBSTEPS, low half first;
//   cfg_ready and point_stall hold during it.
//   Reset: all valid bits clear, registers return to dt = 0.001 and I = 3.14.
//   Stall: a finished item waits in the output register; the cell row keeps
//   advancing until an item reaches its end, then freezes and asserts
//   point_stall until the output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hindmarsh_rose_euler_step_unit
	import hres_pkg::*;
#(
	parameter int SUBSTEPS  = SUBSTEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,

	input  logic                 point_valid,
	output logic                 point_stall,
	input  logic [VAL_W-1:0]     fast_in,
	input  logic [VAL_W-1:0]     recovery_in,
	input  logic [VAL_W-1:0]     adaptation_in,

	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [VAL_W-1:0]     fast_out,
	output logic [VAL_W-1:0]     recovery_out,
	output logic [VAL_W-1:0]     adaptation_out,
	output logic                 saturated
);

	// Reciprocal of SUBSTEPS, rounded up, with enough fraction bits that
	// the product floors exactly for every 33-bit step.
	localparam int RecL   = $clog2(SUBSTEPS);
	localparam int RecS   = DT_W + RecL;
	localparam int RecMW  = DT_W + 2;
	localparam int RecLoW = 18;
	localparam int RecHiW = RecMW - RecLoW;
	localparam int RecPW  = DT_W + RecMW;
	localparam logic [RecMW-1:0]  RecM   =
		RecMW'(((longint'(1) << RecS) + longint'(SUBSTEPS) - 1) / longint'(SUBSTEPS));
	localparam logic [RecLoW-1:0] RecMLo = RecM[RecLoW-1:0];
	localparam logic [RecHiW-1:0] RecMHi = RecM[RecMW-1:RecLoW];
	localparam logic [VAL_W-1:0]  HReset = VAL_W'(DT_RESET / SUBSTEPS);

	// Configuration registers and the substep-size divider.
	logic [VAL_W-1:0]        h_q;
	logic [VAL_W-1:0]        cur_q;
	logic                    div_busy_q;
	logic                    div_ph_q;
	logic [DT_W-1:0]         div_num_q;
	logic [DT_W+RecLoW-1:0]  div_lo_q;

	logic [DT_W+RecLoW-1:0]  rec_lo;
	logic [DT_W+RecHiW-1:0]  rec_hi;
	logic [RecPW-1:0]        rec_sum;

	// Cell row links: link 0 is the accepted input, link SUBSTEPS the end.
	hres_pt_t          link_pt [0:SUBSTEPS];
	logic [SUBSTEPS:0] link_vld;

	logic              en;
	logic              res_vld_q;
	hres_pt_t          res_q;

	// Multiply by the reciprocal in two halves; the low half is registered first.
	assign rec_lo  = div_num_q * RecMLo;
	assign rec_hi  = div_num_q * RecMHi;
	assign rec_sum = {rec_hi, {RecLoW{1'b0}}} + RecPW'(div_lo_q);

	assign cfg_ready = !div_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q        <= HReset;
			cur_q      <= CUR_RESET;
			div_busy_q <= 1'b0;
			div_ph_q   <= 1'b0;
			div_num_q  <= '0;
			div_lo_q   <= '0;
		end else if (div_busy_q) begin
			if (!div_ph_q) begin
				div_lo_q <= rec_lo;
				div_ph_q <= 1'b1;
			end else begin
				h_q        <= VAL_W'(rec_sum >> RecS);
				div_busy_q <= 1'b0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIME_STEP: begin
					div_busy_q <= 1'b1;
					div_ph_q   <= 1'b0;
					div_num_q  <= cfg_data[DT_W-1:0];
				end
				CFG_INPUT_CURRENT: begin
					cur_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the whole row unless a finished item would collide with a
	// stalled output register.
	assign en          = !link_vld[SUBSTEPS] || !res_vld_q || !result_stall;
	assign point_stall = !en || div_busy_q;

	assign link_vld[0]     = point_valid && !point_stall;
	assign link_pt[0].flag = 1'b0;
	assign link_pt[0].x    = fast_in;
	assign link_pt[0].y    = recovery_in;
	assign link_pt[0].z    = adaptation_in;

	for (genvar g = 0; g < SUBSTEPS; g++) begin : g_cell
		hres_cell #(
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.step     (h_q),
			.cur      (cur_q),
			.prev_vld (link_vld[g]),
			.prev_pt  (link_pt[g]),
			.next_vld (link_vld[g+1]),
			.next_pt  (link_pt[g+1])
		);
	end

	// Output register: load from the row end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en && link_vld[SUBSTEPS]) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && link_vld[SUBSTEPS])
			res_q <= link_pt[SUBSTEPS];
	end

	assign result_valid   = res_vld_q;
	assign fast_out       = res_q.x;
	assign recovery_out   = res_q.y;
	assign adaptation_out = res_q.z;
	assign saturated      = res_q.flag;

	a_div_blocks_points: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> point_stall)
		else $error("point accepted while the step divider runs");

	a_full_row_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(link_vld[SUBSTEPS] && res_vld_q && result_stall) |-> (point_stall && !en))
		else $error("cell row advanced into a stalled output register");

	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !result_stall && !link_vld[SUBSTEPS]) |=> !res_vld_q)
		else $error("taken result not released");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hindmarsh_rose_euler_step_unit
// Streams (x, y, z) points through the Euler step unit and checks every
// advanced point and its saturation flag against a bit-true fixed-point
// predictor kept in step with the configuration writes. Runs a directed list
// first and then randomized settings phases, with random idling on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------

module testbench;
	import hres_pkg::*;

	// Substep count and fraction width of the default build.
	localparam int NSUB       = 11;
	localparam int FRAC_Q     = 32;
	// Pipeline depth, used for the quiet tail at the end.
	localparam int PIPE_DEPTH = NSUB * 15 + 1;

	localparam int NPHASE      = 7;
	localparam int PHASE_ITEMS = 270;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 250000;
	localparam int REPORT_CAP  = 40;

	// Register indexes with no register behind them; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Q15.32 limits and model constants.
	localparam longint Q_MAX  = 64'sd140737488355327;
	localparam longint Q_MIN  = -64'sd140737488355328;
	localparam longint ONE_Q  = 64'sd4294967296;
	localparam longint RATE_Q = (ONE_Q * 2 + 500) / 1000;
	localparam longint XR_Q   = -((ONE_Q * 16 + 5) / 10);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [127:0]     wide_t;

	typedef enum logic {
		ROW_POINT,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 known;
		logic [CFG_IDX_W-1:0] idx;
		logic [VAL_W-1:0]     data;
		logic [VAL_W-1:0]     x;
		logic [VAL_W-1:0]     y;
		logic [VAL_W-1:0]     z;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 point_valid;
	logic                 point_stall;
	logic [VAL_W-1:0]     fast_in;
	logic [VAL_W-1:0]     recovery_in;
	logic [VAL_W-1:0]     adaptation_in;
	logic                 result_valid;
	logic                 result_stall;
	logic [VAL_W-1:0]     fast_out;
	logic [VAL_W-1:0]     recovery_out;
	logic [VAL_W-1:0]     adaptation_out;
	logic                 saturated;

	// Predictor copy of the two registers, at their reset values.
	logic [DT_W-1:0] dt_q  = 33'd4294967;
	val_t            cur_q = 48'sd13486197309;

	hres_pt_t pending_points[$];
	row_t     directed_rows[$];

	bit clip_seen;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int point_count, result_count, sat_count, write_count, mismatch_count;
	int cycle_count;

	hindmarsh_rose_euler_step_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.point_valid    (point_valid),
		.point_stall    (point_stall),
		.fast_in        (fast_in),
		.recovery_in    (recovery_in),
		.adaptation_in  (adaptation_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.fast_out       (fast_out),
		.recovery_out   (recovery_out),
		.adaptation_out (adaptation_out),
		.saturated      (saturated)
	);

	always #2 clk = ~clk;

	// Watchdog: a correct run ends far below this count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				pending_points.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------------

	// Clamp to the Q15.32 range; note that a clamp happened.
	function automatic longint clip(wide_t v);
		if (v > Q_MAX) begin
			clip_seen = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			clip_seen = 1'b1;
			return Q_MIN;
		end
		return v[63:0];
	endfunction

	// Product with the low fraction bits dropped (floor), then clamped.
	function automatic longint mul_q(longint a, longint b);
		wide_t pa;
		wide_t pb;
		pa = a;
		pb = b;
		return clip((pa * pb) >>> FRAC_Q);
	endfunction

	// Advance one point by a full time step of NSUB Euler substeps.
	function automatic hres_pt_t advance_point(val_t xi, val_t yi, val_t zi);
		longint   x, y, z, cur, h;
		longint   x2, x3, t, dx, dy, dz;
		hres_pt_t r;
		clip_seen = 1'b0;
		x   = xi;
		y   = yi;
		z   = zi;
		cur = cur_q;
		h   = dt_q / NSUB;
		for (int s = 0; s < NSUB; s++) begin
			x2 = mul_q(x, x);
			x3 = mul_q(x2, x);
			// dx = y - x^3 + 3 x^2 - z + I
			t  = clip(-x3);
			t  = clip(t + clip(3 * x2));
			dx = clip(y + t);
			dx = clip(dx - z);
			dx = clip(dx + cur);
			// dy = 1 - 5 x^2 - y
			dy = clip(ONE_Q - clip(5 * x2));
			dy = clip(dy - y);
			// dz = r (s (x - xR) - z)
			t  = clip(x - XR_Q);
			t  = clip(4 * t);
			t  = clip(t - z);
			dz = mul_q(RATE_Q, t);
			// All three rates come from the values before this substep.
			x = clip(x + mul_q(h, dx));
			y = clip(y + mul_q(h, dy));
			z = clip(z + mul_q(h, dz));
		end
		r.flag = clip_seen;
		r.x    = x[VAL_W-1:0];
		r.y    = y[VAL_W-1:0];
		r.z    = z[VAL_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic [VAL_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[VAL_W-1:0];
	endfunction

	// Value between lo and hi thousandths, with random low fraction bits.
	function automatic logic [VAL_W-1:0] pick_real(int lo, int hi);
		longint m;
		longint v;
		m = lo + int'($urandom_range(0, hi - lo));
		v = (m * ONE_Q) / 1000 + $urandom_range(0, 65535);
		return v[VAL_W-1:0];
	endfunction

	task automatic put_point(input logic [VAL_W-1:0] x, y, z);
		directed_rows.push_back('{ROW_POINT, 1'b0, CFG_TIME_STEP, '0, x, y, z});
	endtask

	// Row whose result is known: the point passes through untouched.
	task automatic put_known(input logic [VAL_W-1:0] x, y, z);
		directed_rows.push_back('{ROW_POINT, 1'b1, CFG_TIME_STEP, '0, x, y, z});
	endtask

	task automatic put_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		directed_rows.push_back('{ROW_WRITE, 1'b0, idx, data, '0, '0, '0});
	endtask

	// Drop valid and wait until every issued point has come back.
	task automatic drain_results();
		point_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only ever issued with the pipeline empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TIME_STEP:     dt_q  = data[DT_W-1:0];
			CFG_INPUT_CURRENT: cur_q = data;
			default: ;
		endcase
		write_count++;
	endtask

	// Offer one point, hold it until taken, then queue its expected result.
	task automatic push_point(input logic [VAL_W-1:0] px, py, pz, input bit known);
		hres_pt_t want;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		point_valid   <= 1'b1;
		fast_in       <= px;
		recovery_in   <= py;
		adaptation_in <= pz;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		if (known)
			want = '{1'b0, px, py, pz};
		else
			want = advance_point(px, py, pz);
		pending_points.push_back(want);
		point_count++;
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stalls, the long hold-off, and the checks
	// ------------------------------------------------------------------------

	task automatic report_field(input string name, input logic [VAL_W-1:0] want,
		input logic [VAL_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
	endtask

	initial begin
		int       stall_left;
		hres_pt_t want;
		stall_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && !result_stall) begin
				result_count++;
				if (saturated === 1'b1)
					sat_count++;
				if (pending_points.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: unexpected result, expected none, actual %h %h %h %b",
						$time, fast_out, recovery_out, adaptation_out, saturated);
				end else begin
					want = pending_points.pop_front();
					if (fast_out !== want.x)
						report_field("fast_out", want.x, fast_out);
					if (recovery_out !== want.y)
						report_field("recovery_out", want.y, recovery_out);
					if (adaptation_out !== want.z)
						report_field("adaptation_out", want.z, adaptation_out);
					if (saturated !== want.flag)
						report_field("saturated", want.flag, saturated);
				end
			end
			// Pick the stall for the next cycle: a pending hold-off wins over
			// the short random bursts.
			if (stall_left == 0) begin
				if (hold_request) begin
					hold_request = 1'b0;
					stall_left   = HOLD_CYCLES;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 7);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		int               sel;
		logic [DT_W-1:0]  dt;
		logic [14:0]      dt_upper;
		logic [VAL_W-1:0] cur, px, py, pz, edge_val;
		row_t             row;

		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_TIME_STEP;
		cfg_data      <= '0;
		point_valid   <= 1'b0;
		fast_in       <= '0;
		recovery_in   <= '0;
		adaptation_in <= '0;

		// Hold reset, then release on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed list. The first rows run on the reset register values.
		put_point('0, '0, '0);
		put_point(VAL_MAX, '0, '0);                       // x^3 overflows
		put_point(VAL_MIN, '0, '0);
		put_point('0, VAL_MAX, VAL_MIN);                  // dx overflows upward
		put_point('0, VAL_MIN, VAL_MAX);                  // and downward
		put_point(VAL_MAX, VAL_MAX, VAL_MAX);
		put_point(VAL_MIN, VAL_MIN, VAL_MIN);
		put_point(48'hFFFE_6666_6666, 48'hFFF6_0000_0000, '0);   // x near xR
		put_point(48'h0001_8000_0000, 48'hFFF6_0000_0000, 48'h0002_0000_0000);
		put_write(CFG_INPUT_CURRENT, VAL_MAX);
		put_point(48'h0000_8000_0000, '0, '0);
		put_write(CFG_INPUT_CURRENT, VAL_MIN);
		put_point(48'h0000_8000_0000, '0, '0);
		// Largest step; the bits above the register width must be ignored.
		put_write(CFG_TIME_STEP, '1);
		put_point(48'h0001_0000_0000, 48'h0001_0000_0000, 48'h0001_0000_0000);
		put_point(48'hFFFE_0000_0000, 48'h0003_0000_0000, 48'h0000_4000_0000);
		// Writes to indexes with no register must change nothing.
		put_write(CFG_SPARE_2, '0);
		put_write(CFG_SPARE_3, '1);
		put_point(48'h0000_4000_0000, '0, '0);
		// Step below the substep count: points pass unchanged, though a clamp
		// inside the rate terms still raises the flag.
		put_write(CFG_TIME_STEP, 48'hFFFE_0000_0005);
		put_point(VAL_MAX, VAL_MIN, VAL_MAX);
		put_point(VAL_MIN, VAL_MAX, VAL_MIN);
		put_point(48'h0000_0000_3039, '1, 48'h0003_0000_0000);
		put_write(CFG_TIME_STEP, VAL_W'(NSUB - 1));
		put_known('0, '0, '0);
		// Smallest nonzero substep.
		put_write(CFG_TIME_STEP, VAL_W'(NSUB));
		put_point(48'h0001_0000_0000, 48'hFFF6_0000_0000, 48'h0002_0000_0000);
		put_write(CFG_TIME_STEP, '0);
		put_known('1, '1, '1);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE)
				write_reg(row.idx, row.data);
			else
				push_point(row.x, row.y, row.z, row.known);
		end

		// Random phases, each on fresh settings. Phase 1 carries the long
		// output hold-off; phase 2 and the last phase run with no idling.
		for (int p = 0; p < NPHASE; p++) begin
			idle_on = !(p == 2 || p == NPHASE - 1);
			case (p)
				2: begin
					dt  = '1;
					cur = rand48();
				end
				3: begin
					dt  = {1'($urandom_range(0, 1)), $urandom()};
					cur = VAL_MAX;
				end
				4: begin
					dt  = DT_W'($urandom_range(0, NSUB - 1));
					cur = VAL_MIN;
				end
				5: begin
					dt  = DT_W'($urandom_range(1 << 22, 1 << 28));
					cur = rand48();
				end
				default: begin
					dt  = DT_W'($urandom_range(1 << 22, 1 << 28));
					cur = pick_real(0, 5000);
				end
			endcase
			dt_upper = 15'($urandom());
			write_reg(CFG_TIME_STEP, {dt_upper, dt});
			write_reg(CFG_INPUT_CURRENT, cur);
			if (p == 3)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, rand48());
			if (p == 1)
				hold_request = 1'b1;

			repeat (PHASE_ITEMS) begin
				sel = $urandom_range(0, 99);
				// Mostly points on the neuron's own orbit scale.
				px = pick_real(-2500, 2500);
				py = pick_real(-15000, 2000);
				pz = pick_real(-500, 4500);
				if (sel >= 70 && sel < 85) begin
					px = rand48();
					py = rand48();
					pz = rand48();
				end else if (sel >= 85 && sel < 93) begin
					case ($urandom_range(0, 3))
						0:       edge_val = VAL_MAX;
						1:       edge_val = VAL_MIN;
						2:       edge_val = '0;
						default: edge_val = '1;
					endcase
					case ($urandom_range(0, 2))
						0:       px = edge_val;
						1:       py = edge_val;
						default: pz = edge_val;
					endcase
				end else if (sel >= 93) begin
					// Large x drives the cube into saturation.
					px = pick_real(-60000, 60000);
				end
				push_point(px, py, pz, 1'b0);
			end
		end

		// Let everything come back, then watch a quiet stretch for strays.
		drain_results();
		repeat (PIPE_DEPTH + 40) @(posedge clk);

		$display("Ran %0d points and %0d register writes over %0d settings phases;",
			point_count, write_count, NPHASE);
		$display("%0d results carried the saturation flag, %0d mismatches seen.",
			sat_count, mismatch_count);
		if (mismatch_count == 0 && pending_points.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hres_pkg.sv
rtl/hres_mul.sv
rtl/hres_cell.sv
rtl/hindmarsh_rose_euler_step_unit.sv
tb/sv/testbench.sv
